FILE: rtl/bmie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bmie_pkg;

  localparam int MEM_DEPTH_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int REG_COUNT_DEF   = 8;

  // instruction codes
  localparam logic [4:0] MODE_RESET   = 5'd0;
  localparam logic [4:0] MODE_INC     = 5'd1;
  localparam logic [4:0] MODE_DEC     = 5'd2;
  localparam logic [4:0] MODE_INPUT   = 5'd3;
  localparam logic [4:0] MODE_DISPLAY = 5'd4;
  localparam logic [4:0] MODE_PUSH    = 5'd5;
  localparam logic [4:0] MODE_POP     = 5'd6;
  localparam logic [4:0] MODE_MOV     = 5'd7;
  localparam logic [4:0] MODE_ADD     = 5'd8;
  localparam logic [4:0] MODE_SUB     = 5'd9;
  localparam logic [4:0] MODE_MUL     = 5'd10;
  localparam logic [4:0] MODE_DIV     = 5'd11;
  localparam logic [4:0] MODE_ROL     = 5'd12;
  localparam logic [4:0] MODE_ROR     = 5'd13;
  localparam logic [4:0] MODE_SHL     = 5'd14;
  localparam logic [4:0] MODE_SHR     = 5'd15;
  localparam logic [4:0] MODE_LOAD    = 5'd16;
  localparam logic [4:0] MODE_STORE   = 5'd17;

  // second operand kinds
  localparam logic [1:0] KIND_IMM = 2'd0;
  localparam logic [1:0] KIND_REG = 2'd1;
  localparam logic [1:0] KIND_MEM = 2'd2;

  // flag selects for RESET
  localparam logic [1:0] FSEL_CARRY = 2'd0;
  localparam logic [1:0] FSEL_OVER  = 2'd1;
  localparam logic [1:0] FSEL_UNDER = 2'd2;
  localparam logic [1:0] FSEL_ZERO  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_STACK_FULL  = 3'd1;
  localparam logic [2:0] ERR_STACK_EMPTY = 3'd2;
  localparam logic [2:0] ERR_DIV_ZERO    = 3'd3;
  localparam logic [2:0] ERR_ADDR        = 3'd4;

  typedef struct packed {
    logic [4:0]         mode;
    logic [2:0]         reg_a;
    logic [2:0]         reg_b;
    logic [1:0]         operand_kind;
    logic signed [15:0] immediate;
    logic [1:0]         flag_select;
    logic signed [15:0] input_value;
  } in_t;

  typedef struct packed {
    logic signed [7:0] display_value;
    logic              display_valid;
    logic [2:0]        error_code;
    logic              halted;
    logic [7:0]        program_counter;
    logic              flag_overflow;
    logic              flag_underflow;
    logic              flag_carry;
    logic              flag_zero;
    logic [3:0]        stack_depth;
  } out_t;

  // register index modulo the register count, by repeated subtraction
  function automatic logic [3:0] reg_mod(logic [2:0] v, int unsigned n);
    logic [4:0] r;
    r = {2'b00, v};
    for (int i = 0; i < 4; i++) begin
      if (r >= 5'(n)) begin
        r = r - 5'(n);
      end
    end
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bmie_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bmie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/bmie_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bmie_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [7:0]       quotient
);

  // restoring divide of unsigned magnitudes, one quotient bit a cycle
  logic        running;
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic        take;

  assign trial = {rem, quotient[7]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 4'd8;
      end else if (running) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      rem      <= take ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quotient <= {quotient[6:0], take};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/byte_machine_instruction_executor_core.sv
// sequence: accept, reads of register a, register b, then memory and stack,
// execute (DIV adds divider start and run); a new item is taken only once the
// last has executed; the reads are dependent, through the single read port of
// the register file, data memory and stack memories; DIV runs an 8-step divider
// reset: synchronous, clears registers, memory valid bits, flags, counters
`timescale 1ns / 1ps
`default_nettype none
module byte_machine_instruction_executor_core
  import bmie_pkg::*;
#(
  parameter int MEM_DEPTH   = MEM_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int REG_COUNT   = REG_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bmie_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bmie_pkg::out_t     out_data
);

  localparam int RW  = $clog2(REG_COUNT);
  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RA   = 3'd1;  // register a read returns
  localparam logic [2:0] S_RB   = 3'd2;  // register b read returns
  localparam logic [2:0] S_MEM  = 3'd3;  // memory and stack reads return
  localparam logic [2:0] S_DIVS = 3'd4;  // divider start
  localparam logic [2:0] S_DIV  = 3'd5;  // divider running
  localparam logic [2:0] S_EXEC = 3'd6;  // execute and write back

  logic [2:0] state, state_next;

  // item latched at accept and per-item operands
  in_t              in_q;
  logic [RW-1:0]    ra_q, rb_q;
  logic [7:0]       dst_q, rbv_q, memv_q, stkv_q;
  logic signed [15:0] src_q;
  logic [AW-1:0]    addr_q;
  logic             addr_ok_q, mem_used_q;

  // architectural state outside the memories
  logic [CW-1:0]    count_q, count_next;
  logic [7:0]       pc_q, pc_next;
  logic             stopped_q, stopped_next;
  logic             f_over, f_under, f_carry, f_zero;
  logic             f_over_next, f_under_next, f_carry_next, f_zero_next;
  logic [REG_COUNT-1:0] rf_valid;
  logic [MEM_DEPTH-1:0] dm_valid;

  // memory ports
  logic [RW-1:0]    rf_raddr;
  logic [7:0]       rf_rdata, rf_wdata;
  logic             rf_we;
  logic [AW-1:0]    dm_raddr;
  logic [7:0]       dm_rdata;
  logic             dm_we;
  logic [SAW-1:0]   st_raddr;
  logic [7:0]       st_rdata;
  logic             st_we;

  // divider
  logic             div_start, div_done;
  logic [7:0]       div_q;
  logic [7:0]       dst_mag;
  logic [15:0]      src_mag;

  // combinational helpers
  logic [7:0]       rbv_c, memv_c;
  logic signed [15:0] src_c;
  logic [AW-1:0]    addr_c;
  logic             addr_ok_c, mem_used_c;
  logic             accept, exec_fire;
  logic signed [7:0]  dst_s;
  logic signed [23:0] prod;
  logic signed [24:0] r;
  logic             use_arith;
  logic [2:0]       err;
  logic             fatal, disp;
  logic [15:0]      rot_l, rot_r;
  logic [3:0]       ra_mod, rb_mod;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign exec_fire = (state == S_EXEC) && (!out_valid || out_ready);
  assign ra_mod    = reg_mod(in_data.reg_a, REG_COUNT);
  assign rb_mod    = reg_mod(in_data.reg_b, REG_COUNT);
  assign dst_s     = signed'(dst_q);

  // register file read port: a at accept, b in the next cycle
  assign rf_raddr = (state == S_IDLE) ? ra_mod[RW-1:0] : rb_q;

  // address of the memory access, formed as register b returns
  assign rbv_c = rf_valid[rb_q] ? rf_rdata : 8'd0;
  always_comb begin
    mem_used_c = (in_q.mode == MODE_LOAD) || (in_q.mode == MODE_STORE) ||
                 ((in_q.mode inside {[MODE_MOV:MODE_SHR]}) &&
                  (in_q.operand_kind == KIND_MEM));
    if (((in_q.mode == MODE_LOAD) || (in_q.mode == MODE_STORE)) &&
        (in_q.operand_kind == KIND_IMM)) begin
      addr_ok_c = !in_q.immediate[15] &&
                  ($unsigned(in_q.immediate) < 16'(MEM_DEPTH));
      addr_c    = in_q.immediate[AW-1:0];
    end else begin
      addr_ok_c = {1'b0, rbv_c} < 9'(MEM_DEPTH);
      addr_c    = rbv_c[AW-1:0];
    end
  end
  assign dm_raddr = addr_c;
  assign st_raddr = SAW'(count_q - 1'b1);

  // second operand, formed as the memory read returns
  assign memv_c = (addr_ok_q && dm_valid[addr_q]) ? dm_rdata : 8'd0;
  always_comb begin
    case (in_q.operand_kind)
      KIND_REG: src_c = {{8{rbv_q[7]}}, rbv_q};
      KIND_MEM: src_c = {{8{memv_c[7]}}, memv_c};
      default:  src_c = in_q.immediate;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_RA;
      S_RA:   state_next = S_RB;
      S_RB:   state_next = S_MEM;
      S_MEM: begin
        if ((in_q.mode == MODE_DIV) && (src_c != 16'sd0) && !stopped_q) begin
          state_next = S_DIVS;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_DIVS: state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_EXEC;
      S_EXEC: if (exec_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
      ra_q <= ra_mod[RW-1:0];
      rb_q <= rb_mod[RW-1:0];
    end
    if (state == S_RA) begin
      dst_q <= rf_valid[ra_q] ? rf_rdata : 8'd0;
    end
    if (state == S_RB) begin
      rbv_q      <= rbv_c;
      addr_q     <= addr_c;
      addr_ok_q  <= addr_ok_c;
      mem_used_q <= mem_used_c;
    end
    if (state == S_MEM) begin
      memv_q <= memv_c;
      stkv_q <= st_rdata;
      src_q  <= src_c;
    end
  end

  // divider on magnitudes, sign fixed afterwards
  assign div_start = (state == S_DIVS);
  assign dst_mag   = dst_q[7] ? 8'(-dst_q) : dst_q;
  assign src_mag   = src_q[15] ? 16'(-src_q) : src_q;

  bmie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dst_mag),
    .divisor  (src_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  assign prod  = dst_s * src_q;
  assign rot_l = {dst_q, dst_q} << src_q[2:0];
  assign rot_r = {dst_q, dst_q} >> src_q[2:0];

  // execute: result, flags, write-back
  always_comb begin
    r            = '0;
    use_arith    = 1'b0;
    err          = (mem_used_q && !addr_ok_q) ? ERR_ADDR : ERR_NONE;
    fatal        = 1'b0;
    disp         = 1'b0;
    rf_we        = 1'b0;
    rf_wdata     = 8'd0;
    dm_we        = 1'b0;
    st_we        = 1'b0;
    count_next   = count_q;
    f_over_next  = f_over;
    f_under_next = f_under;
    f_carry_next = f_carry;
    f_zero_next  = f_zero;
    if (!stopped_q) begin
      case (in_q.mode)
        MODE_RESET: begin
          case (in_q.flag_select)
            FSEL_CARRY: f_carry_next = 1'b0;
            FSEL_OVER:  f_over_next  = 1'b0;
            FSEL_UNDER: f_under_next = 1'b0;
            default:    f_zero_next  = 1'b0;
          endcase
        end
        MODE_INC, MODE_DEC: begin
          r = (in_q.mode == MODE_INC) ? 25'(dst_s) + 25'sd1 : 25'(dst_s) - 25'sd1;
          use_arith = 1'b1;
        end
        MODE_INPUT: begin
          f_over_next  = in_q.input_value > 16'sd127;
          f_under_next = in_q.input_value < -16'sd128;
          f_carry_next = 1'b0;
          f_zero_next  = in_q.input_value == 16'sd0;
          rf_we        = 1'b1;
          rf_wdata     = in_q.input_value[7:0];
        end
        MODE_DISPLAY: disp = 1'b1;
        MODE_PUSH: begin
          if (count_q == CW'(STACK_DEPTH)) begin
            err   = ERR_STACK_FULL;
            fatal = 1'b1;
          end else begin
            st_we      = 1'b1;
            count_next = count_q + 1'b1;
          end
        end
        MODE_POP: begin
          if (count_q == '0) begin
            err   = ERR_STACK_EMPTY;
            fatal = 1'b1;
          end else begin
            rf_we      = 1'b1;
            rf_wdata   = stkv_q;
            count_next = count_q - 1'b1;
          end
        end
        MODE_MOV: begin
          rf_we    = 1'b1;
          rf_wdata = src_q[7:0];
        end
        MODE_ADD: begin
          r = 25'(dst_s) + 25'(src_q);
          use_arith = 1'b1;
        end
        MODE_SUB: begin
          r = 25'(dst_s) - 25'(src_q);
          use_arith = 1'b1;
        end
        MODE_MUL: begin
          r = 25'(prod);
          use_arith = 1'b1;
        end
        MODE_DIV: begin
          if (src_q == 16'sd0) begin
            err   = ERR_DIV_ZERO;
            fatal = 1'b1;
          end else begin
            r = (dst_q[7] ^ src_q[15]) ? -25'(div_q) : 25'(div_q);
            use_arith = 1'b1;
          end
        end
        MODE_ROL: begin
          rf_we    = 1'b1;
          rf_wdata = rot_l[15:8];
        end
        MODE_ROR: begin
          rf_we    = 1'b1;
          rf_wdata = rot_r[7:0];
        end
        MODE_SHL, MODE_SHR: begin
          rf_we = 1'b1;
          if (src_q < 16'sd0 || src_q > 16'sd7) begin
            rf_wdata = 8'd0;
          end else if (in_q.mode == MODE_SHL) begin
            rf_wdata = dst_q << src_q[2:0];
          end else begin
            rf_wdata = dst_q >> src_q[2:0];
          end
        end
        MODE_LOAD: begin
          rf_we    = 1'b1;
          rf_wdata = memv_q;
        end
        MODE_STORE: dm_we = addr_ok_q;
        default: ;
      endcase
      if (use_arith) begin
        f_over_next  = r > 25'sd127;
        f_under_next = r < -25'sd128;
        f_carry_next = (r > 25'sd127) || (r < -25'sd128);
        f_zero_next  = r[7:0] == 8'd0;
        rf_we        = 1'b1;
        rf_wdata     = r[7:0];
      end
    end
    stopped_next = stopped_q || fatal;
    pc_next      = (!stopped_q && !fatal) ? pc_q + 8'd1 : pc_q;
  end

  bmie_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf (
    .clk   (clk),
    .we    (rf_we && exec_fire),
    .waddr (ra_q),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  bmie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_dm (
    .clk   (clk),
    .we    (dm_we && exec_fire),
    .waddr (addr_q),
    .wdata (dst_q),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  bmie_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
    .clk   (clk),
    .we    (st_we && exec_fire),
    .waddr (count_q[SAW-1:0]),
    .wdata (dst_q),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // architectural state and valid bits, committed on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      count_q   <= '0;
      pc_q      <= '0;
      stopped_q <= 1'b0;
      f_over    <= 1'b0;
      f_under   <= 1'b0;
      f_carry   <= 1'b0;
      f_zero    <= 1'b0;
      rf_valid  <= '0;
      dm_valid  <= '0;
    end else if (exec_fire) begin
      count_q   <= count_next;
      pc_q      <= pc_next;
      stopped_q <= stopped_next;
      f_over    <= f_over_next;
      f_under   <= f_under_next;
      f_carry   <= f_carry_next;
      f_zero    <= f_zero_next;
      if (rf_we) begin
        rf_valid[ra_q] <= 1'b1;
      end
      if (dm_we) begin
        dm_valid[addr_q] <= 1'b1;
      end
    end
  end

  // output register; holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data.display_value   <= disp ? signed'(dst_q) : 8'sd0;
      out_data.display_valid   <= disp;
      out_data.error_code      <= stopped_q ? ERR_NONE : err;
      out_data.halted          <= stopped_next;
      out_data.program_counter <= pc_next;
      out_data.flag_overflow   <= f_over_next;
      out_data.flag_underflow  <= f_under_next;
      out_data.flag_carry      <= f_carry_next;
      out_data.flag_zero       <= f_zero_next;
      out_data.stack_depth     <= 4'(count_next);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bmie_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bmie_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire bmie_pkg::in_t in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire bmie_pkg::out_t out_data
);
  import bmie_pkg::*;

  // an offered input item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // fatal errors always come with the halted mark
  a_fatal_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.error_code == ERR_STACK_FULL ||
                  out_data.error_code == ERR_STACK_EMPTY ||
                  out_data.error_code == ERR_DIV_ZERO) |-> out_data.halted)
    else $error("fatal error without halt");

  // a display never reports an error and never comes from a halted machine
  a_display_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.display_valid |->
      out_data.error_code == ERR_NONE && !out_data.halted)
    else $error("display with error or halt");

  // stack depth never exceeds its capacity
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.stack_depth <= 4'(STACK_DEPTH_DEF))
    else $error("stack depth out of range");

endmodule

bind byte_machine_instruction_executor_core bmie_checker u_bmie_checker (.*);
`default_nettype wire
